FILE: hdl/rfv_pkg.sv
// Package for the rectangle fourth-vertex generator.
// Holds the shared constants and the single-precision compare helpers.
// No dependencies.
`timescale 1ns / 1ps

package rfv_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LANE_DEPTH = 5;
	localparam int unsigned VECTOR_LEN_DEF = 4;
	localparam logic [WORD_W-1:0] QNAN = 32'h7fc0_0000;

	function automatic logic fp_is_nan(input logic [WORD_W-1:0] v);
		fp_is_nan = (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
	endfunction

	// IEEE less-than: false when either side is NaN, and zeros of either sign are equal.
	function automatic logic fp_lt(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		logic both_zero;
		both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		if (fp_is_nan(a) || fp_is_nan(b) || both_zero) begin
			fp_lt = 1'b0;
		end else begin
			case ({a[31], b[31]})
				2'b00: fp_lt = a[30:0] < b[30:0];
				2'b11: fp_lt = a[30:0] > b[30:0];
				2'b10: fp_lt = 1'b1;
				default: fp_lt = 1'b0;
			endcase
		end
	endfunction

endpackage

FILE: hdl/rfv_lane.sv
// One axis lane: min/max, single-precision midpoint and halving pipeline.
// Depends on rfv_pkg. The final compare and select is combinational; the merging stage registers it.
`timescale 1ns / 1ps

module rfv_lane
	import rfv_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	input  logic [WORD_W-1:0] c,
	output logic [WORD_W-1:0] pick
);

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] lz;
		lz = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) begin
				lz = 5'(26 - i);
			end
		end
		lzc27 = lz;
	endfunction

	// Stage 1: minimum and maximum, operands kept for the final compare.
	logic [WORD_W-1:0] a_s1, b_s1, c_s1, lo_s1, hi_s1;
	logic [WORD_W-1:0] in_min, in_max;

	always_comb begin
		in_min = fp_lt(c, b) ? c : b;
		in_max = fp_lt(b, c) ? c : b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a;
			b_s1  <= b;
			c_s1  <= c;
			lo_s1 <= fp_lt(in_min, a) ? in_min : a;
			hi_s1 <= fp_lt(a, in_max) ? in_max : a;
		end
	end

	// Stage 2: order by magnitude and align the smaller significand.
	logic [WORD_W-1:0] a_s2, b_s2, c_s2, lo_s2, hi_s2;
	logic [26:0] mb_s2, ms_s2;
	logic [7:0]  e_s2;
	logic        sub_s2, sgn_s2, spec_s2;
	logic [WORD_W-1:0] specv_s2;

	logic [WORD_W-1:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [26:0] mb, ms, msh;
	logic        st, spec;
	logic [WORD_W-1:0] specv;

	always_comb begin
		big = (lo_s1[30:0] < hi_s1[30:0]) ? hi_s1 : lo_s1;
		sml = (lo_s1[30:0] < hi_s1[30:0]) ? lo_s1 : hi_s1;
		eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb  = {big[30:23] != 8'd0, big[22:0], 3'b000};
		ms  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		d   = eb - es;
		if (d >= 8'd27) begin
			msh = 27'd0;
			st  = |ms;
		end else begin
			msh = ms >> d;
			st  = |(ms & ~(27'h7ff_ffff << d));
		end
		msh[0] = msh[0] | st;
		spec  = 1'b0;
		specv = QNAN;
		if (fp_is_nan(lo_s1) || fp_is_nan(hi_s1)) begin
			spec = 1'b1;
		end else if (big[30:23] == 8'hff) begin
			spec = 1'b1;
			// Infinities of opposite sign give NaN, otherwise the infinity stands.
			if (!((sml[30:23] == 8'hff) && (sml[31] != big[31]))) begin
				specv = big;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			lo_s2    <= lo_s1;
			hi_s2    <= hi_s1;
			mb_s2    <= mb;
			ms_s2    <= msh;
			e_s2     <= eb;
			sub_s2   <= big[31] ^ sml[31];
			sgn_s2   <= big[31];
			spec_s2  <= spec;
			specv_s2 <= specv;
		end
	end

	// Stage 3: add or subtract, then normalize.
	logic [WORD_W-1:0] a_s3, b_s3, c_s3, lo_s3, hi_s3;
	logic [26:0] r_s3;
	logic [8:0]  e_s3;
	logic        sgn_s3, spec_s3;
	logic [WORD_W-1:0] specv_s3;

	logic [27:0] sum;
	logic [26:0] rn;
	logic [8:0]  en_e;
	logic [4:0]  lz;
	logic [7:0]  lim, sh;

	always_comb begin
		sum = sub_s2 ? ({1'b0, mb_s2} - {1'b0, ms_s2}) : ({1'b0, mb_s2} + {1'b0, ms_s2});
		lz  = lzc27(sum[26:0]);
		lim = e_s2 - 8'd1;
		sh  = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
		if (sum[27]) begin
			rn   = {sum[27:2], sum[1] | sum[0]};
			en_e = {1'b0, e_s2} + 9'd1;
		end else begin
			rn   = sum[26:0] << sh;
			en_e = {1'b0, e_s2} - {1'b0, sh};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			c_s3     <= c_s2;
			lo_s3    <= lo_s2;
			hi_s3    <= hi_s2;
			r_s3     <= rn;
			e_s3     <= en_e;
			sgn_s3   <= sgn_s2;
			spec_s3  <= spec_s2;
			specv_s3 <= specv_s2;
		end
	end

	// Stage 4: round to nearest even and pack the sum.
	logic [WORD_W-1:0] a_s4, b_s4, c_s4, lo_s4, hi_s4, sum_s4;
	logic [24:0] m25;
	logic [23:0] mr;
	logic [8:0]  er;
	logic        up;
	logic [WORD_W-1:0] packed_sum;

	always_comb begin
		up  = r_s3[2] & (r_s3[1] | r_s3[0] | r_s3[3]);
		m25 = {1'b0, r_s3[26:3]} + {24'd0, up};
		if (m25[24]) begin
			mr = m25[24:1];
			er = e_s3 + 9'd1;
		end else begin
			mr = m25[23:0];
			er = e_s3;
		end
		if (spec_s3) begin
			packed_sum = specv_s3;
		end else if (er >= 9'd255) begin
			packed_sum = {sgn_s3, 8'hff, 23'd0};
		end else if (mr[23]) begin
			packed_sum = {sgn_s3, er[7:0], mr[22:0]};
		end else begin
			packed_sum = {sgn_s3, 8'd0, mr[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= a_s3;
			b_s4   <= b_s3;
			c_s4   <= c_s3;
			lo_s4  <= lo_s3;
			hi_s4  <= hi_s3;
			sum_s4 <= packed_sum;
		end
	end

	// Stage 5: halve the sum; tiny values shift right with round to nearest even.
	logic [WORD_W-1:0] a_s5, b_s5, c_s5, lo_s5, hi_s5, mid_s5;
	logic [23:0] sig, q;
	logic [WORD_W-1:0] half;

	always_comb begin
		sig = {sum_s4[30:23] == 8'd1, sum_s4[22:0]};
		q   = (sig >> 1) + {23'd0, sig[0] & sig[1]};
		if (sum_s4[30:23] == 8'hff) begin
			half = sum_s4;
		end else if (sum_s4[30:23] >= 8'd2) begin
			half = {sum_s4[31], sum_s4[30:23] - 8'd1, sum_s4[22:0]};
		end else begin
			half = {sum_s4[31], 7'd0, q};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5   <= a_s4;
			b_s5   <= b_s4;
			c_s5   <= c_s4;
			lo_s5  <= lo_s4;
			hi_s5  <= hi_s4;
			mid_s5 <= half;
		end
	end

	// Count the operands below the midpoint; fewer than two chooses the minimum.
	logic [1:0] below;

	always_comb begin
		below = {1'b0, fp_lt(a_s5, mid_s5)} + {1'b0, fp_lt(b_s5, mid_s5)}
			+ {1'b0, fp_lt(c_s5, mid_s5)};
		pick = (below < 2'd2) ? lo_s5 : hi_s5;
	end

endmodule

FILE: hdl/rect_fourth_vertex_gen.sv
// Top level of the rectangle fourth-vertex generator.
// Depends on rfv_pkg and rfv_lane (one lane each for x and y).
`timescale 1ns / 1ps

// Usage:
// The input channel carries one word per rectangle: three corners, with z and w
// of the first corner. The output channel returns one word per input word, the
// missing fourth corner. Both channels use valid and stall; a word moves at a
// rising edge where valid is high and stall is low.
// Each coordinate goes through its own lane: min/max selection, a
// single-precision add with round to nearest even, normalization, rounding,
// halving, and then the merging stage compares the three values against the
// midpoint and registers the chosen corner.
// An accepted input word passes through the lane stages and the merging stage.
// One word per clock unless the output stalls; the lanes are fully pipelined.
// The pipeline and its output register advance together. When the receiver
// stalls a valid output, the whole pipeline holds and the input stall rises in
// the same cycle; no word is lost or repeated.
// Reset clears the valid bits of every stage and of the output; data
// registers are not reset. z and w are delayed alongside and are driven as zero
// when VECTOR_LEN does not include them.

module rect_fourth_vertex_gen
	import rfv_pkg::*;
#(
	parameter int unsigned VECTOR_LEN = VECTOR_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] v0_x,
	input  logic [WORD_W-1:0] v0_y,
	input  logic [WORD_W-1:0] v0_z,
	input  logic [WORD_W-1:0] v0_w,
	input  logic [WORD_W-1:0] v1_x,
	input  logic [WORD_W-1:0] v1_y,
	input  logic [WORD_W-1:0] v2_x,
	input  logic [WORD_W-1:0] v2_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] v3_x,
	output logic [WORD_W-1:0] v3_y,
	output logic [WORD_W-1:0] v3_z,
	output logic [WORD_W-1:0] v3_w
);

	// The pipeline moves whenever the output register is empty or being taken.
	logic en;
	logic out_valid_q;
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Valid bits track words through the lane stages.
	logic [LANE_DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_DEPTH-2:0], in_valid};
		end
	end

	logic [WORD_W-1:0] pick_x, pick_y;

	rfv_lane u_lane_x (
		.clk  (clk),
		.en   (en),
		.a    (v0_x),
		.b    (v1_x),
		.c    (v2_x),
		.pick (pick_x)
	);

	rfv_lane u_lane_y (
		.clk  (clk),
		.en   (en),
		.a    (v0_y),
		.b    (v1_y),
		.c    (v2_y),
		.pick (pick_y)
	);

	// z and w ride along with the lanes when the vector has them.
	logic [WORD_W-1:0] z_dly, w_dly;

	generate
		if (VECTOR_LEN >= 3) begin : g_z
			logic [WORD_W-1:0] z_q [LANE_DEPTH];
			always_ff @(posedge clk) begin
				if (en) begin
					z_q[0] <= v0_z;
					for (int i = 1; i < LANE_DEPTH; i++) begin
						z_q[i] <= z_q[i-1];
					end
				end
			end
			assign z_dly = z_q[LANE_DEPTH-1];
		end else begin : g_no_z
			assign z_dly = '0;
		end
		if (VECTOR_LEN >= 4) begin : g_w
			logic [WORD_W-1:0] w_q [LANE_DEPTH];
			always_ff @(posedge clk) begin
				if (en) begin
					w_q[0] <= v0_w;
					for (int i = 1; i < LANE_DEPTH; i++) begin
						w_q[i] <= w_q[i-1];
					end
				end
			end
			assign w_dly = w_q[LANE_DEPTH-1];
		end else begin : g_no_w
			assign w_dly = '0;
		end
	endgenerate

	// Merging stage: the two lane results and the copied words form one output word.
	logic [WORD_W-1:0] x_q, y_q, z_q, w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[LANE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= pick_x;
			y_q <= pick_y;
			z_q <= z_dly;
			w_q <= w_dly;
		end
	end

	assign out_valid = out_valid_q;
	assign v3_x      = x_q;
	assign v3_y      = y_q;
	assign v3_z      = z_q;
	assign v3_w      = w_q;

endmodule

FILE: test/tb_rect_fourth_vertex_gen.sv
// Testbench for rect_fourth_vertex_gen: drives rectangle corner words with random
// gaps and output stalls, predicts each fourth corner with a bit-level float model,
// and checks every result word in order. Depends on rfv_pkg and the block itself.
`timescale 1ns / 1ps

module tb_rect_fourth_vertex_gen;
	import rfv_pkg::*;

	// One input word: three corners, with z and w of the first corner.
	typedef struct {
		logic [WORD_W-1:0] ax, ay, az, aw, bx, by, cx, cy;
	} rect_word_t;

	// One result word: the missing corner.
	typedef struct {
		logic [WORD_W-1:0] x, y, z, w;
	} corner_word_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [WORD_W-1:0] v0_x, v0_y, v0_z, v0_w, v1_x, v1_y, v2_x, v2_y;
	logic              out_valid;
	logic              out_stall;
	logic [WORD_W-1:0] v3_x, v3_y, v3_z, v3_w;

	rect_word_t   pending_rects[$];
	corner_word_t expected_corners[$];
	int           error_count;
	int           taken_count;
	int           offered_count;
	int           corner_count;
	int           seen_corner_count;
	int           send_gap;
	int           hold_cycles;
	int           long_hold;

	rect_fourth_vertex_gen dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z), .v0_w(v0_w),
		.v1_x(v1_x), .v1_y(v1_y), .v2_x(v2_x), .v2_y(v2_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.v3_x(v3_x), .v3_y(v3_y), .v3_z(v3_z), .v3_w(v3_w)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------------------
	// Float helpers. Single words are widened to doubles exactly, and doubles are
	// narrowed back with round to nearest even, subnormals included. A sum of two
	// singles rounded first to double and then to single is still correctly
	// rounded, so the midpoint comes out exactly as single arithmetic gives it.
	// ---------------------------------------------------------------------------

	function automatic bit is_nan_word(input logic [WORD_W-1:0] w);
		return (w[30:23] == 8'hff) && (w[22:0] != 23'd0);
	endfunction

	function automatic real single_to_real(input logic [WORD_W-1:0] w);
		logic [63:0] d;
		logic [22:0] f;
		int          p;
		f = w[22:0];
		if (w[30:23] == 8'hff) begin
			d = {w[31], 11'h7ff, 52'd0};
		end else if (w[30:23] == 8'd0) begin
			if (f == 23'd0) begin
				d = {w[31], 63'd0};
			end else begin
				// Subnormal: normalize so that the leading one becomes the hidden bit.
				p = 22;
				while (!f[p])
					p--;
				d = {w[31], 11'(p - 149 + 1023), 52'(64'(f) << (52 - p))};
			end
		end else begin
			d = {w[31], 11'(int'(w[30:23]) + 896), f, 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	function automatic logic [WORD_W-1:0] round_to_single(input real r);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		int          ex;
		int          shift;
		bit          normal;
		d = $realtobits(r);
		if (d[62:52] == 11'h7ff)
			return {d[63], 8'hff, 23'd0};
		if (d[62:52] == 11'd0)
			return {d[63], 31'd0};
		ex = int'(d[62:52]) - 1023;
		if (ex > 127)
			return {d[63], 8'hff, 23'd0};
		sig = {11'd0, 1'b1, d[51:0]};
		normal = (ex >= -126);
		shift = normal ? 29 : 29 + (-126 - ex);
		if (shift > 60)
			return {d[63], 31'd0};
		kept = sig >> shift;
		rem = sig & ((64'd1 << shift) - 64'd1);
		half = 64'd1 << (shift - 1);
		if (rem > half || (rem == half && kept[0]))
			kept = kept + 64'd1;
		if (!normal)
			return {d[63], kept[30:0]};
		if (kept[24]) begin
			kept = kept >> 1;
			ex++;
		end
		if (ex > 127)
			return {d[63], 8'hff, 23'd0};
		return {d[63], 8'(ex + 127), kept[22:0]};
	endfunction

	// IEEE less-than on single words; any NaN makes it false.
	function automatic bit single_lt(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		if (is_nan_word(a) || is_nan_word(b))
			return 1'b0;
		return single_to_real(a) < single_to_real(b);
	endfunction

	// Picks the fourth coordinate of one axis from the three given ones.
	function automatic logic [WORD_W-1:0] fourth_coord(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c);
		logic [WORD_W-1:0] inner, lo, hi, sum, mid;
		int                below;
		inner = single_lt(c, b) ? c : b;
		lo = single_lt(inner, a) ? inner : a;
		inner = single_lt(b, c) ? c : b;
		hi = single_lt(a, inner) ? inner : a;
		// A NaN midpoint makes every compare false, so nothing lies below it.
		if (is_nan_word(lo) || is_nan_word(hi))
			return lo;
		if (lo[30:0] == 31'h7f80_0000 && hi[30:0] == 31'h7f80_0000 && lo[31] != hi[31])
			return lo;
		sum = round_to_single(single_to_real(lo) + single_to_real(hi));
		mid = round_to_single(single_to_real(sum) * 0.5);
		below = int'(single_lt(a, mid)) + int'(single_lt(b, mid)) + int'(single_lt(c, mid));
		return (below < 2) ? lo : hi;
	endfunction

	function automatic corner_word_t predict_corner(input rect_word_t r);
		corner_word_t c;
		c.x = fourth_coord(r.ax, r.bx, r.cx);
		c.y = fourth_coord(r.ay, r.by, r.cy);
		c.z = (VECTOR_LEN_DEF >= 3) ? r.az : '0;
		c.w = (VECTOR_LEN_DEF >= 4) ? r.aw : '0;
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		error_count++;
	endtask

	// ---------------------------------------------------------------------------
	// Stimulus. Values are drawn from classes so that special encodings show up
	// often: zeros of both signs, subnormals, infinities, NaNs, and values near
	// the top of the range where the midpoint sum overflows.
	// ---------------------------------------------------------------------------

	function automatic logic [WORD_W-1:0] draw_value();
		logic [WORD_W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:0] = 31'd0;
			1: v[30:23] = 8'd0;
			2: v = {v[31], 8'hff, 23'd0};
			3: v[30:23] = 8'hff;
			4: v[30:23] = 8'($urandom_range(250, 254));
			5, 6: v[30:23] = 8'($urandom_range(120, 135));
			default: ;
		endcase
		return v;
	endfunction

	// Three coordinates of a genuine rectangle: two share one value, the third
	// holds the other, in any order. Sometimes the values come from small
	// integers so that ties with the midpoint are common.
	task automatic draw_axis(output logic [WORD_W-1:0] a, output logic [WORD_W-1:0] b,
			output logic [WORD_W-1:0] c);
		logic [WORD_W-1:0] p, q;
		if ($urandom_range(0, 3) == 0) begin
			p = round_to_single(real'($urandom_range(0, 8)) - 4.0);
			q = round_to_single(real'($urandom_range(0, 8)) - 4.0);
		end else begin
			p = draw_value();
			q = draw_value();
		end
		case ($urandom_range(0, 2))
			0: begin a = p; b = p; c = q; end
			1: begin a = p; b = q; c = p; end
			default: begin a = q; b = p; c = p; end
		endcase
	endtask

	task automatic add_rect(input logic [WORD_W-1:0] ax, input logic [WORD_W-1:0] ay,
			input logic [WORD_W-1:0] bx, input logic [WORD_W-1:0] by,
			input logic [WORD_W-1:0] cx, input logic [WORD_W-1:0] cy);
		rect_word_t r;
		r.ax = ax; r.ay = ay; r.bx = bx; r.by = by; r.cx = cx; r.cy = cy;
		r.az = $urandom;
		r.aw = $urandom;
		pending_rects.push_back(r);
	endtask

	initial begin
		logic [WORD_W-1:0] ax, bx, cx, ay, by, cy;
		rect_word_t r;
		// Plain rectangle, then degenerate and extreme ones.
		add_rect(32'h0000_0000, 32'h0000_0000, 32'h3f80_0000, 32'h0000_0000,
			32'h0000_0000, 32'h3f80_0000);
		add_rect(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0000);
		add_rect(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff);
		// Signed zeros: both sides equal, the exact bit pattern must pass through.
		add_rect(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h0000_0000);
		// Midpoint sum overflows to infinity.
		add_rect(32'h7f7f_ffff, 32'hff7f_ffff, 32'h7f7f_ffff, 32'hff7f_ffff,
			32'h7f00_0000, 32'h7f7f_ffff);
		add_rect(32'hff7f_ffff, 32'h7f7f_ffff, 32'h7f7f_ffff, 32'h7f7f_fffe,
			32'hff7f_ffff, 32'h7f7f_ffff);
		// Infinities, including opposite infinities whose sum is NaN.
		add_rect(32'h7f80_0000, 32'hff80_0000, 32'hff80_0000, 32'h7f80_0000,
			32'h7f80_0000, 32'h3f80_0000);
		add_rect(32'hff80_0000, 32'h7f80_0000, 32'h4000_0000, 32'h7f80_0000,
			32'hff80_0000, 32'h4000_0000);
		// NaNs with payloads in each position.
		add_rect(32'h7fc0_1234, 32'h3f80_0000, 32'h3f80_0000, 32'hffbf_ffff,
			32'h4000_0000, 32'h3f80_0000);
		add_rect(32'h3f80_0000, 32'h7f80_0001, 32'hffc0_0000, 32'h4000_0000,
			32'h4000_0000, 32'h4000_0000);
		add_rect(32'h4000_0000, 32'h4040_0000, 32'h4000_0000, 32'h7fff_ffff,
			32'h7fa0_0000, 32'h4040_0000);
		// Subnormals, where the halving rounds.
		add_rect(32'h0000_0001, 32'h8000_0001, 32'h0000_0000, 32'h8000_0001,
			32'h0000_0001, 32'h0000_0000);
		add_rect(32'h007f_ffff, 32'h0000_0003, 32'h007f_ffff, 32'h0000_0001,
			32'h0080_0000, 32'h0000_0003);
		// Three distinct values, so the count decides; the last word repeats two values.
		add_rect(32'h3f80_0000, 32'hc000_0000, 32'h4000_0000, 32'h4120_0000,
			32'h4120_0000, 32'hbf80_0000);
		add_rect(32'hbf80_0000, 32'h4040_0000, 32'h3f80_0000, 32'h3f80_0000,
			32'h0000_0000, 32'h4000_0000);
		add_rect(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
			32'h5555_5555, 32'haaaa_aaaa);
		// Random part: mostly real rectangles, the rest arbitrary words.
		repeat (1150) begin
			if ($urandom_range(0, 3) == 0) begin
				r.ax = $urandom; r.ay = $urandom; r.bx = $urandom;
				r.by = $urandom; r.cx = $urandom; r.cy = $urandom;
				if ($urandom_range(0, 1))
					begin r.bx = draw_value(); r.cy = draw_value(); end
				add_rect(r.ax, r.ay, r.bx, r.by, r.cx, r.cy);
			end else begin
				draw_axis(ax, bx, cx);
				draw_axis(ay, by, cy);
				add_rect(ax, ay, bx, by, cx, cy);
			end
		end
	end

	// Reset and the end of the run.
	initial begin
		error_count = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_rects.size() == 0 && taken_count == offered_count && in_valid == 1'b0);
		wait (expected_corners.size() == 0);
		// The pipeline is six stages deep; give it a little more to show strays.
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb_rect_fourth_vertex_gen: clean");
		else
			$display("tb_rect_fourth_vertex_gen: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_rect_fourth_vertex_gen: timeout");
		$display("tb_rect_fourth_vertex_gen: errors");
		$finish;
	end

	// ---------------------------------------------------------------------------
	// Sender. It changes the pins at the falling edge only. A word that is taken
	// at a rising edge shows up as taken_count catching up with offered_count.
	// ---------------------------------------------------------------------------

	initial begin
		in_valid = 1'b0;
		{v0_x, v0_y, v0_z, v0_w, v1_x, v1_y, v2_x, v2_y} = '0;
		offered_count = 0;
		send_gap = 0;
	end

	always @(negedge clk) begin
		rect_word_t r;
		logic       next_valid;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && taken_count == offered_count)
				next_valid = 1'b0;
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_rects.size() != 0) begin
					r = pending_rects.pop_front();
					v0_x <= r.ax; v0_y <= r.ay; v0_z <= r.az; v0_w <= r.aw;
					v1_x <= r.bx; v1_y <= r.by; v2_x <= r.cx; v2_y <= r.cy;
					next_valid = 1'b1;
					offered_count++;
					// Runs of back-to-back words alternate with gappy stretches.
					send_gap = (offered_count % 300 < 80) ? 0 : $urandom_range(0, 11);
				end
			end
		end
		in_valid <= next_valid;
	end

	// Input side: every accepted word gets its prediction queued.
	always @(posedge clk or negedge arst_n) begin
		rect_word_t r;
		if (!arst_n) begin
			taken_count <= 0;
		end else if (in_valid && !in_stall) begin
			r.ax = v0_x; r.ay = v0_y; r.az = v0_z; r.aw = v0_w;
			r.bx = v1_x; r.by = v1_y; r.cx = v2_x; r.cy = v2_y;
			expected_corners.push_back(predict_corner(r));
			taken_count <= taken_count + 1;
		end
	end

	// ---------------------------------------------------------------------------
	// Receiver. After each word it draws a stall length. Once, after some
	// words have come back, it holds off for a long stretch so the pipeline fills
	// and pushes the stall back to the sender.
	// ---------------------------------------------------------------------------

	initial begin
		out_stall = 1'b1;
		hold_cycles = 0;
		long_hold = 0;
		seen_corner_count = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (seen_corner_count != corner_count) begin
				seen_corner_count = corner_count;
				if (corner_count == 200)
					long_hold = 60;
				hold_cycles = (corner_count % 250 < 70) ? 0 : $urandom_range(0, 11);
			end
			if (long_hold > 0) begin
				long_hold--;
				out_stall <= 1'b1;
			end else if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Output side: each taken word is checked field by field against the oldest
	// prediction.
	always @(posedge clk or negedge arst_n) begin
		corner_word_t want;
		if (!arst_n) begin
			corner_count <= 0;
		end else if (out_valid && !out_stall) begin
			corner_count <= corner_count + 1;
			if (expected_corners.size() == 0) begin
				$display("%0t: result word with nothing expected", $realtime);
				error_count++;
			end else begin
				want = expected_corners.pop_front();
				if (v3_x !== want.x) report_mismatch("v3_x", v3_x, want.x);
				if (v3_y !== want.y) report_mismatch("v3_y", v3_y, want.y);
				if (v3_z !== want.z) report_mismatch("v3_z", v3_z, want.z);
				if (v3_w !== want.w) report_mismatch("v3_w", v3_w, want.w);
			end
		end
	end

endmodule
